[hdl/battery_health_estimator_core_assert.svh]
// assertion macros for the battery health estimator core
// used by battery_health_estimator_core.sv, needs a clock and an active-low reset
`ifndef BATTERY_HEALTH_ESTIMATOR_CORE_ASSERT_SVH
`define BATTERY_HEALTH_ESTIMATOR_CORE_ASSERT_SVH

// same-cycle implication
`define BHE_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("bhe assertion failed");

// next-cycle implication
`define BHE_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("bhe assertion failed");

`endif

[hdl/bhe_pkg.sv]
// shared types, widths and constants of the battery health estimator
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package bhe_pkg;

	localparam int CODE_W = 3;
	localparam int PCT_W = 7;
	localparam int UAH_W = 32;
	localparam int TOT_P_W = 16;
	localparam int TOT_U_W = 48;
	localparam int EST_W = 24;
	localparam int HLTH_W = 16;
	localparam int CAP_W = 16;
	localparam int MIN_W = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam int DIV_NUM_W = 56;
	localparam int DIV_DEN_W = 32;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [TOT_P_W-1:0] PCT_MAX = '1;
	localparam logic [TOT_U_W-1:0] UAH_MAX = '1;
	localparam logic [EST_W-1:0] EST_MAX = '1;
	localparam logic [HLTH_W-1:0] HLTH_MAX = '1;

	localparam logic [CAP_W-1:0] DESIGN_CAP_RST = 16'd5000;
	localparam logic [MIN_W-1:0] MIN_PCT_RST = 8'd30;

	localparam logic [CFG_IDX_W-1:0] CFG_DESIGN_CAP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PCT = 1'b1;

	localparam logic [CODE_W-1:0] STAT_UNKNOWN = 3'd0;
	localparam logic [CODE_W-1:0] STAT_DISCHARGING = 3'd1;
	localparam logic [CODE_W-1:0] STAT_CHARGING = 3'd2;
	localparam logic [CODE_W-1:0] STAT_FULL = 3'd3;
	localparam logic [CODE_W-1:0] STAT_NOT_CHARGING = 3'd4;

	typedef enum logic [2:0] {
		EV_CLOSED = 3'd0,
		EV_START = 3'd1,
		EV_REBASE = 3'd2,
		EV_SAME = 3'd3,
		EV_ACCUM = 3'd4,
		EV_EST = 3'd5
	} event_t;

	typedef struct packed {
		event_t kind;
		logic [CODE_W-1:0] state;
		logic [TOT_P_W-1:0] tot_pct;
		logic [TOT_U_W-1:0] tot_uah;
	} entry_t;

	function automatic logic [CODE_W-1:0] decode_status(input logic [CODE_W-1:0] code);
		logic [CODE_W-1:0] res;
		unique case (code) inside
			STAT_UNKNOWN, STAT_DISCHARGING, STAT_CHARGING, STAT_FULL,
			STAT_NOT_CHARGING: res = code;
			default: res = STAT_UNKNOWN;
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

[hdl/battery_health_estimator_core.sv]
// Battery health estimator, top level.
// Input channel: one fuel-gauge sample per word (status_code, capacity_percent,
// charge_counter_uah), taken at a clock edge with in_valid high and in_stall low.
// Output channel: exactly one result word per sample, in order, on out_valid and
// out_stall, with the totals and the last capacity and health estimates.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 design capacity
// in mAh, 1 minimum accumulated percent); write only while the block is idle.
// A two-word queue parts the classifying front end from the back end, so
// samples keep being taken while a result waits to be read.
// A sample that does not update the estimate goes from the queue straight into
// the output word, with the queue empty and the output free. A sample that
// updates the estimate passes the back-end states prep, load, run and fin, while
// the 56-step bit-serial dividers for capacity and health run side by side.
// Throughput: one sample a cycle while no estimate is due and out_stall is low;
// no word leaves the queue while an estimate runs; in_stall rises when the queue is full.
// Reset clears the reference point, the totals and the estimates and restores the
// register defaults (5000 mAh, 30 percent). When the receiver stalls the result
// word holds, the queue fills, and then in_stall is raised.
`timescale 1ns / 1ps
`default_nettype none

`include "battery_health_estimator_core_assert.svh"

module battery_health_estimator_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [bhe_pkg::CODE_W-1:0] status_code,
	input wire logic [bhe_pkg::PCT_W-1:0] capacity_percent,
	input wire logic [bhe_pkg::UAH_W-1:0] charge_counter_uah,
	output logic out_valid,
	input wire logic out_stall,
	output logic [2:0] event_kind,
	output logic [bhe_pkg::CODE_W-1:0] battery_state,
	output logic [bhe_pkg::TOT_P_W-1:0] accumulated_percent,
	output logic [bhe_pkg::TOT_U_W-1:0] accumulated_uah,
	output logic [bhe_pkg::EST_W-1:0] estimated_capacity_mah,
	output logic [bhe_pkg::HLTH_W-1:0] health_tenths,
	input wire logic cfg_we,
	input wire logic [bhe_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [bhe_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [bhe_pkg::CAP_W-1:0] design_cap_q;
	logic [bhe_pkg::MIN_W-1:0] min_pct_q;

	logic accept;
	logic fifo_full;
	logic fifo_empty;
	logic pop;
	bhe_pkg::entry_t front_entry;
	bhe_pkg::entry_t head_entry;

	assign in_stall = fifo_full;
	assign accept = in_valid && !fifo_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			design_cap_q <= bhe_pkg::DESIGN_CAP_RST;
			min_pct_q <= bhe_pkg::MIN_PCT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bhe_pkg::CFG_DESIGN_CAP: design_cap_q <= cfg_data[bhe_pkg::CAP_W-1:0];
				bhe_pkg::CFG_MIN_PCT: min_pct_q <= cfg_data[bhe_pkg::MIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	bhe_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.status_code(status_code),
		.capacity_percent(capacity_percent),
		.charge_counter_uah(charge_counter_uah),
		.min_pct(min_pct_q),
		.entry(front_entry)
	);

	bhe_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept),
		.wr_entry(front_entry),
		.pop(pop),
		.rd_entry(head_entry),
		.full(fifo_full),
		.empty(fifo_empty)
	);

	bhe_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head_entry),
		.empty(fifo_empty),
		.design_cap(design_cap_q),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_kind(event_kind),
		.battery_state(battery_state),
		.accumulated_percent(accumulated_percent),
		.accumulated_uah(accumulated_uah),
		.estimated_capacity_mah(estimated_capacity_mah),
		.health_tenths(health_tenths)
	);

	// totals never shrink from one word to the next
	`BHE_ASSERT_NXT(a_pct_mono, clk, arst_n, out_valid && !out_stall, accumulated_percent >= $past(accumulated_percent))
	`BHE_ASSERT_NXT(a_uah_mono, clk, arst_n, out_valid && !out_stall, accumulated_uah >= $past(accumulated_uah))
	// any state but discharging closes the segment
	`BHE_ASSERT_IMP(a_closed, clk, arst_n, out_valid && battery_state != bhe_pkg::STAT_DISCHARGING, event_kind == bhe_pkg::EV_CLOSED)

endmodule

`default_nettype wire

[hdl/bhe_front.sv]
// front end: classifies each sample against the reference point and keeps the totals
// depends on bhe_pkg
`timescale 1ns / 1ps
`default_nettype none

module bhe_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic accept,
	input wire logic [bhe_pkg::CODE_W-1:0] status_code,
	input wire logic [bhe_pkg::PCT_W-1:0] capacity_percent,
	input wire logic [bhe_pkg::UAH_W-1:0] charge_counter_uah,
	input wire logic [bhe_pkg::MIN_W-1:0] min_pct,
	output bhe_pkg::entry_t entry
);

	logic ref_valid_q;
	logic [bhe_pkg::PCT_W-1:0] ref_pct_q;
	logic [bhe_pkg::UAH_W-1:0] ref_uah_q;
	logic [bhe_pkg::TOT_P_W-1:0] tot_pct_q;
	logic [bhe_pkg::TOT_U_W-1:0] tot_uah_q;

	logic nxt_ref_valid;
	logic nxt_ref_load;
	logic [bhe_pkg::CODE_W-1:0] state;
	bhe_pkg::event_t kind;
	logic [bhe_pkg::PCT_W-1:0] dp;
	logic [bhe_pkg::UAH_W-1:0] du;
	logic [bhe_pkg::TOT_P_W:0] tp;
	logic [bhe_pkg::TOT_U_W:0] tu;
	logic [bhe_pkg::TOT_P_W-1:0] nxt_tot_pct;
	logic [bhe_pkg::TOT_U_W-1:0] nxt_tot_uah;

	assign state = bhe_pkg::decode_status(status_code);
	assign dp = ref_pct_q - capacity_percent;
	assign du = ref_uah_q - charge_counter_uah;
	assign tp = {1'b0, tot_pct_q} + {{(bhe_pkg::TOT_P_W + 1 - bhe_pkg::PCT_W){1'b0}}, dp};
	assign tu = {1'b0, tot_uah_q} + {{(bhe_pkg::TOT_U_W + 1 - bhe_pkg::UAH_W){1'b0}}, du};

	always_comb begin
		nxt_ref_valid = ref_valid_q;
		nxt_ref_load = 1'b0;
		nxt_tot_pct = tot_pct_q;
		nxt_tot_uah = tot_uah_q;
		if (state != bhe_pkg::STAT_DISCHARGING) begin
			nxt_ref_valid = 1'b0;
			kind = bhe_pkg::EV_CLOSED;
		end else if (!ref_valid_q) begin
			nxt_ref_valid = 1'b1;
			nxt_ref_load = 1'b1;
			kind = bhe_pkg::EV_START;
		end else if (capacity_percent > ref_pct_q || charge_counter_uah > ref_uah_q) begin
			nxt_ref_load = 1'b1;
			kind = bhe_pkg::EV_REBASE;
		end else if (capacity_percent == ref_pct_q || charge_counter_uah == ref_uah_q) begin
			kind = bhe_pkg::EV_SAME;
		end else begin
			nxt_ref_load = 1'b1;
			nxt_tot_pct = tp[bhe_pkg::TOT_P_W] ? bhe_pkg::PCT_MAX : tp[bhe_pkg::TOT_P_W-1:0];
			nxt_tot_uah = tu[bhe_pkg::TOT_U_W] ? bhe_pkg::UAH_MAX : tu[bhe_pkg::TOT_U_W-1:0];
			if (nxt_tot_pct >= {{(bhe_pkg::TOT_P_W - bhe_pkg::MIN_W){1'b0}}, min_pct}) begin
				kind = bhe_pkg::EV_EST;
			end else begin
				kind = bhe_pkg::EV_ACCUM;
			end
		end
	end

	always_comb begin
		entry.kind = kind;
		entry.state = state;
		entry.tot_pct = nxt_tot_pct;
		entry.tot_uah = nxt_tot_uah;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_valid_q <= 1'b0;
			ref_pct_q <= '0;
			ref_uah_q <= '0;
			tot_pct_q <= '0;
			tot_uah_q <= '0;
		end else if (accept) begin
			ref_valid_q <= nxt_ref_valid;
			tot_pct_q <= nxt_tot_pct;
			tot_uah_q <= nxt_tot_uah;
			if (nxt_ref_load) begin
				ref_pct_q <= capacity_percent;
				ref_uah_q <= charge_counter_uah;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/bhe_fifo.sv]
// short queue of classified words between the front end and the back end
// depends on bhe_pkg
`timescale 1ns / 1ps
`default_nettype none

module bhe_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire bhe_pkg::entry_t wr_entry,
	input wire logic pop,
	output bhe_pkg::entry_t rd_entry,
	output logic full,
	output logic empty
);

	bhe_pkg::entry_t mem_q [bhe_pkg::FIFO_DEPTH];
	logic [bhe_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [bhe_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [bhe_pkg::FIFO_CNT_W-1:0] cnt_q;

	assign full = (cnt_q == bhe_pkg::FIFO_CNT_W'(bhe_pkg::FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == bhe_pkg::FIFO_PTR_W'(bhe_pkg::FIFO_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == bhe_pkg::FIFO_PTR_W'(bhe_pkg::FIFO_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/bhe_div.sv]
// restoring divider, one quotient bit per cycle
// depends on bhe_pkg
`timescale 1ns / 1ps
`default_nettype none

module bhe_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [bhe_pkg::DIV_NUM_W-1:0] num,
	input wire logic [bhe_pkg::DIV_DEN_W-1:0] den,
	output logic busy,
	output logic [bhe_pkg::DIV_NUM_W-1:0] quo
);

	logic busy_q;
	logic [bhe_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [bhe_pkg::DIV_DEN_W-1:0] rem_q;
	logic [bhe_pkg::DIV_DEN_W-1:0] den_q;
	logic [bhe_pkg::DIV_NUM_W-1:0] quo_q;

	logic [bhe_pkg::DIV_DEN_W:0] shifted;
	logic [bhe_pkg::DIV_DEN_W+1:0] diff;
	logic neg;

	assign shifted = {rem_q, quo_q[bhe_pkg::DIV_NUM_W-1]};
	assign diff = {1'b0, shifted} - {2'b00, den_q};
	assign neg = diff[bhe_pkg::DIV_DEN_W+1];
	assign busy = busy_q;
	assign quo = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= neg ? shifted[bhe_pkg::DIV_DEN_W-1:0] : diff[bhe_pkg::DIV_DEN_W-1:0];
			quo_q <= {quo_q[bhe_pkg::DIV_NUM_W-2:0], ~neg};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == bhe_pkg::DIV_CNT_W'(bhe_pkg::DIV_NUM_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/bhe_back.sv]
// back end: runs the capacity and health divisions and holds the output word
// depends on bhe_pkg and bhe_div
`timescale 1ns / 1ps
`default_nettype none

module bhe_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire bhe_pkg::entry_t head,
	input wire logic empty,
	input wire logic [bhe_pkg::CAP_W-1:0] design_cap,
	output logic pop,
	output logic out_valid,
	input wire logic out_stall,
	output logic [2:0] event_kind,
	output logic [bhe_pkg::CODE_W-1:0] battery_state,
	output logic [bhe_pkg::TOT_P_W-1:0] accumulated_percent,
	output logic [bhe_pkg::TOT_U_W-1:0] accumulated_uah,
	output logic [bhe_pkg::EST_W-1:0] estimated_capacity_mah,
	output logic [bhe_pkg::HLTH_W-1:0] health_tenths
);

	typedef enum logic [2:0] {
		B_IDLE,
		B_PREP,
		B_LOAD,
		B_RUN,
		B_FIN
	} bstate_t;

	bstate_t state_q;
	bhe_pkg::entry_t item_q;
	logic out_valid_q;
	logic [bhe_pkg::EST_W-1:0] est_q;
	logic [bhe_pkg::HLTH_W-1:0] hlth_q;
	logic [bhe_pkg::DIV_NUM_W-1:0] num_e_q;
	logic [bhe_pkg::DIV_DEN_W-1:0] den_e_q;
	logic [bhe_pkg::DIV_NUM_W-1:0] num_h_q;
	logic [bhe_pkg::DIV_DEN_W-1:0] den_h_q;

	logic [2:0] kind_q;
	logic [bhe_pkg::CODE_W-1:0] bstate_q;
	logic [bhe_pkg::TOT_P_W-1:0] pct_q;
	logic [bhe_pkg::TOT_U_W-1:0] uah_q;
	logic [bhe_pkg::EST_W-1:0] est_out_q;
	logic [bhe_pkg::HLTH_W-1:0] hlth_out_q;

	logic slot_free;
	logic div_start;
	logic busy_e;
	logic busy_h;
	logic [bhe_pkg::DIV_NUM_W-1:0] quo_e;
	logic [bhe_pkg::DIV_NUM_W-1:0] quo_h;
	logic [bhe_pkg::EST_W-1:0] est_sat;
	logic [bhe_pkg::HLTH_W-1:0] hlth_sat;
	logic [bhe_pkg::DIV_NUM_W-1:0] uah_ext;
	logic [bhe_pkg::DIV_NUM_W-1:0] uah_x100;
	logic [bhe_pkg::DIV_DEN_W-1:0] pct_x10;
	logic [bhe_pkg::DIV_DEN_W-1:0] pct_x_cap;

	assign slot_free = !out_valid_q || !out_stall;
	assign pop = (state_q == B_IDLE) && !empty && slot_free;
	assign div_start = (state_q == B_LOAD);

	assign uah_ext = {{(bhe_pkg::DIV_NUM_W - bhe_pkg::TOT_U_W){1'b0}}, item_q.tot_uah};
	// x100 as 64 + 32 + 4
	assign uah_x100 = (uah_ext << 6) + (uah_ext << 5) + (uah_ext << 2);
	assign pct_x10 = ({{(bhe_pkg::DIV_DEN_W - bhe_pkg::TOT_P_W){1'b0}}, item_q.tot_pct} << 3)
		+ ({{(bhe_pkg::DIV_DEN_W - bhe_pkg::TOT_P_W){1'b0}}, item_q.tot_pct} << 1);
	assign pct_x_cap = {{(bhe_pkg::DIV_DEN_W - bhe_pkg::TOT_P_W){1'b0}}, item_q.tot_pct}
		* {{(bhe_pkg::DIV_DEN_W - bhe_pkg::CAP_W){1'b0}}, design_cap};

	assign est_sat = (|quo_e[bhe_pkg::DIV_NUM_W-1:bhe_pkg::EST_W]) ?
		bhe_pkg::EST_MAX : quo_e[bhe_pkg::EST_W-1:0];
	assign hlth_sat = (|quo_h[bhe_pkg::DIV_NUM_W-1:bhe_pkg::HLTH_W]) ?
		bhe_pkg::HLTH_MAX : quo_h[bhe_pkg::HLTH_W-1:0];

	bhe_div u_div_est (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(num_e_q),
		.den(den_e_q),
		.busy(busy_e),
		.quo(quo_e)
	);

	bhe_div u_div_hlth (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(num_h_q),
		.den(den_h_q),
		.busy(busy_h),
		.quo(quo_h)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
		if (state_q == B_PREP) begin
			num_e_q <= uah_ext;
			den_e_q <= pct_x10;
			num_h_q <= uah_x100;
			den_h_q <= pct_x_cap;
		end
		if (pop && head.kind != bhe_pkg::EV_EST) begin
			kind_q <= head.kind;
			bstate_q <= head.state;
			pct_q <= head.tot_pct;
			uah_q <= head.tot_uah;
			est_out_q <= est_q;
			hlth_out_q <= hlth_q;
		end else if (state_q == B_FIN && slot_free) begin
			kind_q <= item_q.kind;
			bstate_q <= item_q.state;
			pct_q <= item_q.tot_pct;
			uah_q <= item_q.tot_uah;
			est_out_q <= est_sat;
			hlth_out_q <= hlth_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
			est_q <= '0;
			hlth_q <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						if (head.kind == bhe_pkg::EV_EST) begin
							state_q <= B_PREP;
						end else begin
							out_valid_q <= 1'b1;
						end
					end
				end
				B_PREP: begin
					state_q <= B_LOAD;
				end
				B_LOAD: begin
					state_q <= B_RUN;
				end
				B_RUN: begin
					if (!busy_e && !busy_h) begin
						state_q <= B_FIN;
					end
				end
				B_FIN: begin
					if (slot_free) begin
						est_q <= est_sat;
						hlth_q <= hlth_sat;
						out_valid_q <= 1'b1;
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign event_kind = kind_q;
	assign battery_state = bstate_q;
	assign accumulated_percent = pct_q;
	assign accumulated_uah = uah_q;
	assign estimated_capacity_mah = est_out_q;
	assign health_tenths = hlth_out_q;

endmodule

`default_nettype wire
